// ----- hdl/mmm_pkg.sv -----
// Shared package of the multichannel moving median block.
// Holds sizes, derived widths, payload types, the sequencer state type and the
// control struct of the rank unit. Depends on nothing.
package mmm_pkg;

  localparam int WINDOW_SIZE  = 16;
  localparam int NUM_CHANNELS = 6;

  localparam int SAMPLE_W  = 16;
  localparam int CHANNEL_W = 3;
  localparam int FILL_W    = $clog2(WINDOW_SIZE + 1);
  localparam int IDX_W     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH     = NUM_CHANNELS * WINDOW_SIZE;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CHANNEL_W-1:0]       chan_out_t;
  typedef logic [FILL_W-1:0]          fill_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [CH_W-1:0]            ch_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_LOAD,
    ST_SCAN,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Control of the shared rank unit, driven by the sequencer.
  typedef struct packed {
    logic clear;        // start a new rank count
    logic acc;          // compare the current window entry against the candidate
    logic before_self;  // the current entry sits before the candidate in the window
  } rank_ctl_t;

endpackage

// ----- hdl/mmm_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the per-channel sample windows.
module mmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/mmm_rank.sv -----
// Shared rank unit: one signed comparator and a counter that tallies how many
// window entries order before the candidate. Uses mmm_pkg types.
module mmm_rank (
  input  logic               clk,
  input  mmm_pkg::rank_ctl_t ctl,
  input  mmm_pkg::sample_t   cand,
  input  mmm_pkg::sample_t   entry,
  output mmm_pkg::idx_t      count
);

  logic hit;

  // Ties are broken by window position so exactly one entry has each rank.
  assign hit = (entry < cand) || ((entry == cand) && ctl.before_self);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      count <= '0;
    end else if (ctl.acc) begin
      count <= count + mmm_pkg::idx_t'(hit);
    end
  end

endmodule

// ----- hdl/multichannel_moving_median_top.sv -----
// Top level of the multichannel moving median block.
// Depends on mmm_pkg, mmm_ram (window storage) and mmm_rank (shared comparator).
//
// Usage: signed 16-bit samples enter on the input channel (sample, in_valid,
// in_stall) in fixed round-robin channel order 0 .. NUM_CHANNELS-1. For every
// sample one result leaves on the output channel (median, channel,
// last_channel, fill, out_valid, out_stall). The median is the entry at index
// fill/2 of the channel's window in ascending order, i.e. the upper median for
// an even fill. The write slot and fill count advance after the last channel.
// Timing: the block takes one sample at a time. After the transfer the sample
// is written to the window RAM, then candidates are tried in window order; each
// candidate passes through the states CAND (read), LOAD (load), SCAN (fill
// compares through the single comparator) and CHECK. Once one of the fill
// candidates is found to be the median, the result goes into the output
// register as soon as it is free and the sequencer returns to idle to take the
// next sample. The single read port of the window RAM and the single comparator
// set the time per sample.
// Reset clears the channel counter, write slot, fill count, sequencer and
// output valid, and the input stalls while reset is high; window contents are
// never read before being written.
// While the receiver stalls, the result holds in the output register; the block
// still accepts the next sample and computes it, and only waits at the end if
// the earlier result has not yet been taken.
module multichannel_moving_median_top (
  input  logic                 clk,
  input  logic                 rst,
  input  mmm_pkg::sample_t     sample,
  input  logic                 in_valid,
  output logic                 in_stall,
  output mmm_pkg::sample_t     median,
  output mmm_pkg::chan_out_t   channel,
  output logic                 last_channel,
  output mmm_pkg::fill_t       fill,
  output logic                 out_valid,
  input  logic                 out_stall
);

  // Sequencer and position state.
  mmm_pkg::state_t state;
  mmm_pkg::state_t state_next;
  mmm_pkg::ch_t    ch_cnt;
  mmm_pkg::idx_t   slot;
  mmm_pkg::fill_t  fill_cnt;

  // Per-sample working registers.
  mmm_pkg::ch_t     cur_ch;
  logic             cur_last;
  mmm_pkg::addr_t   cur_base;
  mmm_pkg::fill_t   cur_n;
  mmm_pkg::idx_t    cand_i;
  mmm_pkg::idx_t    scan_j;
  mmm_pkg::sample_t cand;

  // Window RAM and rank unit connections.
  mmm_pkg::addr_t       wr_addr;
  mmm_pkg::addr_t       rd_addr;
  logic [mmm_pkg::SAMPLE_W-1:0] rd_data;
  mmm_pkg::rank_ctl_t   rank_ctl;
  mmm_pkg::idx_t        rank_count;

  logic           accept;
  logic           scan_last;
  logic           found;
  logic           out_free;
  logic           ch_is_last;
  mmm_pkg::fill_t n_new;
  mmm_pkg::addr_t base_new;

  assign in_stall   = rst || (state != mmm_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign ch_is_last = (ch_cnt == mmm_pkg::ch_t'(mmm_pkg::NUM_CHANNELS - 1));

  // Fill count after this sample, saturating at the window size.
  assign n_new = (fill_cnt < mmm_pkg::fill_t'(mmm_pkg::WINDOW_SIZE)) ?
                 fill_cnt + mmm_pkg::fill_t'(1) : mmm_pkg::fill_t'(mmm_pkg::WINDOW_SIZE);
  assign base_new = mmm_pkg::addr_t'(ch_cnt) * mmm_pkg::addr_t'(mmm_pkg::WINDOW_SIZE);
  assign wr_addr  = base_new + mmm_pkg::addr_t'(slot);

  assign scan_last = (mmm_pkg::fill_t'(scan_j) == cur_n - mmm_pkg::fill_t'(1));
  assign found     = (mmm_pkg::fill_t'(rank_count) == (cur_n >> 1));

  always_comb begin
    state_next           = state;
    rd_addr              = cur_base;
    rank_ctl.clear       = 1'b0;
    rank_ctl.acc         = 1'b0;
    rank_ctl.before_self = 1'b0;
    case (state)
      mmm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = mmm_pkg::ST_CAND;
        end
      end
      mmm_pkg::ST_CAND: begin
        rd_addr    = cur_base + mmm_pkg::addr_t'(cand_i);
        state_next = mmm_pkg::ST_LOAD;
      end
      mmm_pkg::ST_LOAD: begin
        // Candidate arrives; start reading the window from entry zero.
        rd_addr        = cur_base;
        rank_ctl.clear = 1'b1;
        state_next     = mmm_pkg::ST_SCAN;
      end
      mmm_pkg::ST_SCAN: begin
        if (!scan_last) begin
          rd_addr = cur_base + mmm_pkg::addr_t'(scan_j) + mmm_pkg::addr_t'(1);
        end
        rank_ctl.acc         = 1'b1;
        rank_ctl.before_self = (scan_j < cand_i);
        if (scan_last) begin
          state_next = mmm_pkg::ST_CHECK;
        end
      end
      mmm_pkg::ST_CHECK: begin
        state_next = found ? mmm_pkg::ST_DONE : mmm_pkg::ST_CAND;
      end
      mmm_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = mmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Channel counter advances per accepted sample; write slot and fill count after the last channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt   <= '0;
      slot     <= '0;
      fill_cnt <= '0;
    end else if (accept) begin
      if (ch_is_last) begin
        ch_cnt   <= '0;
        fill_cnt <= n_new;
        if (slot == mmm_pkg::idx_t'(mmm_pkg::WINDOW_SIZE - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + mmm_pkg::idx_t'(1);
        end
      end else begin
        ch_cnt <= ch_cnt + mmm_pkg::ch_t'(1);
      end
    end
  end

  // Working registers of the current sample.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_ch   <= ch_cnt;
      cur_last <= ch_is_last;
      cur_base <= base_new;
      cur_n    <= n_new;
      cand_i   <= '0;
    end
    if (state == mmm_pkg::ST_LOAD) begin
      cand   <= mmm_pkg::sample_t'(rd_data);
      scan_j <= '0;
    end
    if ((state == mmm_pkg::ST_SCAN) && !scan_last) begin
      scan_j <= scan_j + mmm_pkg::idx_t'(1);
    end
    if ((state == mmm_pkg::ST_CHECK) && !found) begin
      cand_i <= cand_i + mmm_pkg::idx_t'(1);
    end
  end

  // Output register; it holds its result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == mmm_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == mmm_pkg::ST_DONE) && out_free) begin
      median       <= cand;
      channel      <= mmm_pkg::chan_out_t'(cur_ch);
      last_channel <= cur_last;
      fill         <= cur_n;
    end
  end

  mmm_ram #(
    .WIDTH (mmm_pkg::SAMPLE_W),
    .DEPTH (mmm_pkg::DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_addr),
    .wr_data (sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mmm_rank u_rank (
    .clk   (clk),
    .ctl   (rank_ctl),
    .cand  (cand),
    .entry (mmm_pkg::sample_t'(rd_data)),
    .count (rank_count)
  );

endmodule

// ----- hdl/mmm_checker.sv -----
// Port-level checker of the multichannel moving median block, bound to the top.
// Depends on mmm_pkg and multichannel_moving_median_top.
module mmm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input mmm_pkg::sample_t   median,
  input mmm_pkg::chan_out_t channel,
  input logic               last_channel,
  input mmm_pkg::fill_t     fill,
  input logic               out_valid,
  input logic               out_stall
);

  // A result that is stalled keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(median) && $stable(channel) &&
                                  $stable(last_channel) && $stable(fill)))
    else $error("stalled result changed");

  // One sample at a time: after an input transfer the block stalls its input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // Last channel flag marks exactly the final channel of the vector.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_channel == (channel ==
                   mmm_pkg::chan_out_t'(mmm_pkg::NUM_CHANNELS - 1))))
    else $error("last channel flag mismatch");

  // Reported fill stays within one and the window size.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((fill != '0) && (fill <= mmm_pkg::fill_t'(mmm_pkg::WINDOW_SIZE))))
    else $error("fill out of range");

endmodule

bind multichannel_moving_median_top mmm_checker u_mmm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .median       (median),
  .channel      (channel),
  .last_channel (last_channel),
  .fill         (fill),
  .out_valid    (out_valid),
  .out_stall    (out_stall)
);

// ----- verif/tb_multichannel_moving_median_top.sv -----
// Self-checking testbench for multichannel_moving_median_top.
// Holds a per-channel window predictor, a queue-fed sample driver and a result
// monitor with random gaps and stalls. Depends on mmm_pkg and the block's RTL.
module tb_multichannel_moving_median_top;
  import mmm_pkg::*;

  // Cycles without any transfer before the run is declared hung. This is several
  // times the slowest sample in the block plus the longest sender gap and the
  // longest receiver stall.
  localparam int HANG_LIMIT = 2000;
  // Quiet cycles after the last result, enough to cover one full median pass.
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 400;
  localparam int MAX_WAIT = 18;

  // One result of the block, as the predictor expects it.
  typedef struct {
    sample_t   median;
    chan_out_t channel;
    logic      last_channel;
    fill_t     fill;
  } median_result_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  sample_t   sample = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sample_t   median;
  chan_out_t channel;
  logic      last_channel;
  fill_t     fill;
  logic      out_valid;
  logic      out_stall = 1'b0;

  multichannel_moving_median_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .median       (median),
    .channel      (channel),
    .last_channel (last_channel),
    .fill         (fill),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Samples still to be sent, and the medians that the predictor expects back.
  sample_t        sample_queue[$];
  median_result_t median_queue[$];
  int             total_samples = 0;
  int             sent_samples = 0;
  int             failures = 0;

  // Predictor state: a copy of every channel window, the shared write slot,
  // the number of completed channel vectors (up to the window size) and the channel of the next sample.
  sample_t     window_copy [NUM_CHANNELS][WINDOW_SIZE];
  int unsigned next_chan = 0;
  int unsigned ring_slot = 0;
  int unsigned vectors_done = 0;

  // Inserts one sample into its channel window and queues the median of the
  // window afterwards: the element at index fill/2 in ascending order.
  task automatic predict_median(input sample_t value);
    sample_t        sorted [WINDOW_SIZE];
    sample_t        key;
    median_result_t res;
    int             count;
    int             i;
    int             j;
    window_copy[next_chan][ring_slot] = value;
    count = (vectors_done < WINDOW_SIZE) ? vectors_done + 1 : WINDOW_SIZE;
    // Before the window is full only slots 0..count-1 hold data.
    for (i = 0; i < count; i++) sorted[i] = window_copy[next_chan][i];
    for (i = 1; i < count; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    res.median       = sorted[count / 2];
    res.channel      = chan_out_t'(next_chan);
    res.last_channel = (next_chan == NUM_CHANNELS - 1);
    res.fill         = fill_t'(count);
    median_queue.push_back(res);
    // The slot and fill count move on only once the whole vector is in.
    if (res.last_channel) begin
      ring_slot = (ring_slot + 1) % WINDOW_SIZE;
      vectors_done = count;
      next_chan = 0;
    end else begin
      next_chan++;
    end
  endtask

  // Random sample values: a mix of full-range values, tiny values that make
  // ties common, and values at or next to the two extremes.
  function automatic sample_t random_sample();
    int v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom_range(0, 8);
        random_sample = sample_t'(v - 4);
      end
      1: begin
        v = $urandom_range(0, 2);
        random_sample = $urandom_range(0, 1) ? sample_t'(16'sh7FFF - v)
                                             : sample_t'(16'sh8000 + v);
      end
      default: random_sample = sample_t'($urandom);
    endcase
  endfunction

  // Each side alternates between calm stretches, where it never waits, and
  // busy stretches, where it waits a random number of cycles per item.
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;

  function automatic int draw_wait(ref bit calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    draw_wait = calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Driver. A sample stays on the port with valid high until the block takes
  // it. After each transfer the sender idles for a drawn number of cycles and
  // then presents the next queued sample. Each output gets one assignment.
  int send_gap = 0;

  always @(posedge clk) begin
    logic    next_valid;
    sample_t next_sample;
    bool_hold: begin
    end
    next_valid = in_valid;
    next_sample = sample;
    if (rst) begin
      next_valid = 1'b0;
      send_gap = draw_wait(send_calm);
    end else begin
      if (in_valid && !in_stall) begin
        predict_median(sample);
        sent_samples++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_queue.size() > 0) begin
          next_valid = 1'b1;
          next_sample = sample_queue.pop_front();
          send_gap = draw_wait(send_calm);
        end
      end
    end
    in_valid <= next_valid;
    sample <= next_sample;
  end

  // Monitor. Each result transfer is checked field by field against the
  // oldest expected median. After a transfer the receiver draws how many
  // cycles it will stall the next result; the count only runs down while a
  // result is actually waiting, so every drawn stall is seen by the block.
  int stall_left = 0;

  always @(posedge clk) begin
    median_result_t exp_res;
    if (rst) begin
      stall_left = draw_wait(take_calm);
    end else if (out_valid && !out_stall) begin
      if (median_queue.size() == 0) begin
        $error("unexpected result: median=%0d channel=%0d", median, channel);
        failures++;
      end else begin
        exp_res = median_queue.pop_front();
        if (median !== exp_res.median) begin
          $error("median: expected %0d, got %0d", exp_res.median, median);
          failures++;
        end
        if (channel !== exp_res.channel) begin
          $error("channel: expected %0d, got %0d", exp_res.channel, channel);
          failures++;
        end
        if (last_channel !== exp_res.last_channel) begin
          $error("last_channel: expected %0b, got %0b", exp_res.last_channel,
                 last_channel);
          failures++;
        end
        if (fill !== exp_res.fill) begin
          $error("fill: expected %0d, got %0d", exp_res.fill, fill);
          failures++;
        end
      end
      stall_left = draw_wait(take_calm);
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= !rst && (stall_left > 0);
  end

  // Watchdog: ends the run if no transfer happens on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("tb_multichannel_moving_median_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Directed part. The first vector puts the extremes, zero and the
    // alternating bit pattern 5555 into single-entry windows. The second vector
    // gives every channel a two-entry window, where the upper median must be
    // picked. The third and fourth vectors bring odd and even fills with ties.
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh0000);
    sample_queue.push_back(16'shFFFF);
    sample_queue.push_back(16'sh0001);
    sample_queue.push_back(16'sh5555);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'shAAAA);
    sample_queue.push_back(16'sh0000);
    sample_queue.push_back(16'shFFFF);
    sample_queue.push_back(16'sh0001);
    sample_queue.push_back(16'sh0000);
    sample_queue.push_back(16'sh0000);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'shFFFF);
    sample_queue.push_back(16'sh0001);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'shFFFF);
    sample_queue.push_back(16'sh0001);
    // Random part. With six channels the windows fill after sixteen vectors,
    // so this runs the ring through several wraps of the full window.
    repeat (RANDOM_ITEMS) sample_queue.push_back(random_sample());
    total_samples = sample_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every sample to go in and every median to come out, then give
    // the block time to show any stray result.
    while (sent_samples != total_samples) @(posedge clk);
    while (median_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_multichannel_moving_median_top OK");
    end else begin
      $display("tb_multichannel_moving_median_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mmm_pkg.sv
hdl/mmm_ram.sv
hdl/mmm_rank.sv
hdl/multichannel_moving_median_top.sv
hdl/mmm_checker.sv
verif/tb_multichannel_moving_median_top.sv
